// ===== hw/rtl/pts_pkg.sv =====
// Shared types and constants for the periodic timer scheduler.
// No dependencies; imported by every module of the block.
package pts_pkg;

  localparam int DW     = 32;  // time, period, count and tag width
  localparam int SLOT_W = 4;   // handle width on the ports

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  // write command into the timer table
  typedef struct packed {
    logic          we_due;
    logic          we_int;
    logic          we_cnt;
    logic          we_tag;
    logic          set_vld;
    logic          clr_vld;
    logic [DW-1:0] due;
    logic [DW-1:0] intv;
    logic [DW-1:0] cnt;
    logic [DW-1:0] tag;
  } tbl_wr_t;

  // registered read data of the timer table
  typedef struct packed {
    logic          vld;
    logic [DW-1:0] due;
    logic [DW-1:0] intv;
    logic [DW-1:0] cnt;
    logic [DW-1:0] tag;
  } tbl_rd_t;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] cand;
    logic [DW-1:0] lim;
    logic [DW-1:0] best;
  } alu_in_t;

  typedef struct packed {
    logic [DW-1:0] sum;
    logic          le;   // cand <= lim
    logic          lt;   // cand <  best
  } alu_out_t;

  // one result word
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              accepted;
    logic              fired;
    logic [DW-1:0]     tag;
    logic [DW-1:0]     due;
    logic [DW-1:0]     period;
    logic [DW-1:0]     cnt;
    logic              overflow;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/pts_alu.sv =====
// Shared arithmetic unit: one 32-bit adder and the two due-time compares.
// Depends on pts_pkg.
module pts_alu
  import pts_pkg::*;
(
  input  alu_in_t  alu_i,
  output alu_out_t alu_o
);

  assign alu_o.sum = alu_i.a + alu_i.b;
  assign alu_o.le  = (alu_i.cand <= alu_i.lim);
  assign alu_o.lt  = (alu_i.cand < alu_i.best);

endmodule

// ===== hw/rtl/pts_table.sv =====
// Timer table: due, period, count and tag memories plus per-slot valid flags.
// One write port, one registered read port. Depends on pts_pkg.
module pts_table
  import pts_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int AW         = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] wr_addr,
  input  tbl_wr_t       wr,
  input  logic [AW-1:0] rd_addr,
  output tbl_rd_t       rd
);

  logic [NUM_TIMERS-1:0] vld;
  logic [DW-1:0]         due_mem [NUM_TIMERS];
  logic [DW-1:0]         int_mem [NUM_TIMERS];
  logic [DW-1:0]         cnt_mem [NUM_TIMERS];
  logic [DW-1:0]         tag_mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (wr.set_vld) vld[wr_addr] <= 1'b1;
      if (wr.clr_vld) vld[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_due) due_mem[wr_addr] <= wr.due;
    if (wr.we_int) int_mem[wr_addr] <= wr.intv;
    if (wr.we_cnt) cnt_mem[wr_addr] <= wr.cnt;
    if (wr.we_tag) tag_mem[wr_addr] <= wr.tag;
    rd.vld  <= vld[rd_addr];
    rd.due  <= due_mem[rd_addr];
    rd.intv <= int_mem[rd_addr];
    rd.cnt  <= cnt_mem[rd_addr];
    rd.tag  <= tag_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/periodic_timer_scheduler_top.sv =====
// Periodic timer scheduler, top level: request sequencer and result register.
// Uses pts_pkg, pts_table and pts_alu.
//
// Usage
//   Request channel (req_valid/req_ready) takes one word: add, remove, tick
//   or query. Result channel (res_valid/res_ready) returns the words it
//   causes; last marks the final word of a request. Add, remove and query
//   give one word, a tick one word per firing (or one with fired = 0).
// Sequencing
//   remove clears the slot's valid flag directly, query reads one slot back,
//   and add first scans for a free slot. tick: every scan for the earliest due
//   timer walks the table one slot a cycle through the single read port; each
//   firing then updates the count and, unless it reaches zero, the due time on
//   the shared adder before the next scan. req_ready is high only when idle.
// Stalls
//   Results sit in an output register; a firing is held one scan deep so
//   last/overflow can be decided. If res_ready stays low the sequencer waits
//   at its next result without losing state.
// Reset
//   All slots free, no result pending, ready for a request. Table contents
//   are undefined until a timer is added.
module periodic_timer_scheduler_top
  import pts_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int MAX_FIRES  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_type,
  input  logic [DW-1:0]      now_time,
  input  logic [DW-1:0]      period,
  input  logic [DW-1:0]      first_delay,
  input  logic signed [31:0] repeat_count,
  input  logic [DW-1:0]      user_tag,
  input  logic [SLOT_W-1:0]  target_slot,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [SLOT_W-1:0]  slot_out,
  output logic               accepted,
  output logic               fired,
  output logic [DW-1:0]      tag_out,
  output logic [DW-1:0]      due_out,
  output logic [DW-1:0]      period_out,
  output logic signed [31:0] count_out,
  output logic               overflow,
  output logic               last
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int XW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;  // target range check
  localparam int FW = $clog2(MAX_FIRES + 1);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a request
    S_EXEC,    // remove / start query read
    S_QRY,     // query data back from table
    S_SCAN,    // walk the table: free slot (add) or earliest due (tick)
    S_ADD,     // write new timer
    S_DECIDE,  // tick: fire next, or finish
    S_FCNT,    // tick: update count
    S_FDUE     // tick: advance due time
  } state_t;

  state_t state;

  // captured request
  req_t              r_type;
  logic [DW-1:0]     r_now;
  logic [DW-1:0]     r_period;
  logic [DW-1:0]     r_first;
  logic [DW-1:0]     r_count;
  logic [DW-1:0]     r_tag;
  logic [SLOT_W-1:0] r_tgt;

  // scan pipeline and best candidate
  logic [AW:0]   scan_cnt;
  logic          rd_live;
  logic [AW-1:0] rd_idx;
  logic          found;
  logic [AW-1:0] best_idx;
  logic [DW-1:0] best_due;
  logic [DW-1:0] best_int;
  logic [DW-1:0] best_cnt;
  logic [DW-1:0] best_tag;

  // firing held back until the next scan tells whether it is the last one
  logic          pend_valid;
  logic [AW-1:0] pend_slot;
  logic [DW-1:0] pend_tag;
  logic [FW-1:0] nf;

  res_t res_q;
  res_t ld;
  logic ld_en;

  tbl_wr_t       wr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  tbl_rd_t       rd;
  alu_in_t       alu_i;
  alu_out_t      alu_o;

  logic [XW-1:0] tgt_x;
  logic          tgt_in;
  logic [AW-1:0] tgt_idx;
  logic          out_free;
  logic          scan_end;
  logic          dec_fire;
  logic [DW-1:0] cnt_dec;
  logic          rd_cnt_zero;

  assign tgt_x       = XW'(r_tgt);
  assign tgt_in      = (tgt_x < XW'(NUM_TIMERS));
  assign tgt_idx     = tgt_x[AW-1:0];
  assign out_free    = !res_valid || res_ready;
  assign scan_end    = (scan_cnt == (AW+1)'(NUM_TIMERS)) && !rd_live;
  assign dec_fire    = found && (nf < FW'(MAX_FIRES));
  assign rd_cnt_zero = (rd.cnt == '0);
  // negative counts run forever and are left alone
  assign cnt_dec     = best_cnt[DW-1] ? best_cnt : alu_o.sum;
  assign req_ready   = (state == S_IDLE);

  pts_table #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  pts_alu u_alu (
    .alu_i (alu_i),
    .alu_o (alu_o)
  );

  // operand steering, table writes and result building
  always_comb begin
    ld_en      = 1'b0;
    ld         = '0;
    wr         = '0;
    wr_addr    = best_idx;
    rd_addr    = tgt_idx;
    alu_i.a    = r_now;
    alu_i.b    = r_first;
    alu_i.cand = rd.due;
    alu_i.lim  = r_now;
    alu_i.best = best_due;
    case (state)
      S_EXEC: begin
        if (r_type == REQ_REMOVE && out_free) begin
          ld_en      = 1'b1;
          ld.slot    = r_tgt;
          ld.last    = 1'b1;
          wr_addr    = tgt_idx;
          wr.clr_vld = tgt_in;
        end
      end
      S_QRY: begin
        if (out_free) begin
          ld_en   = 1'b1;
          ld.slot = r_tgt;
          ld.last = 1'b1;
          if (tgt_in && rd.vld) begin
            ld.tag    = rd.tag;
            ld.due    = rd.due;
            ld.period = rd.intv;
            ld.cnt    = rd.cnt;
          end
        end
      end
      S_SCAN: begin
        rd_addr = scan_cnt[AW-1:0];
        // a zero-count timer left by an add is dropped by the next tick
        if (rd_live && r_type == REQ_TICK && rd.vld && rd_cnt_zero) begin
          wr_addr    = rd_idx;
          wr.clr_vld = 1'b1;
        end
      end
      S_ADD: begin
        if (out_free) begin
          ld_en   = 1'b1;
          ld.last = 1'b1;
          if (found) begin
            ld.slot     = SLOT_W'(best_idx);
            ld.accepted = 1'b1;
            wr.we_due   = 1'b1;
            wr.we_int   = 1'b1;
            wr.we_cnt   = 1'b1;
            wr.we_tag   = 1'b1;
            wr.set_vld  = 1'b1;
            wr.due      = alu_o.sum;
            wr.intv     = r_period;
            wr.cnt      = r_count;
            wr.tag      = r_tag;
          end
        end
      end
      S_DECIDE: begin
        ld.fired = pend_valid;
        // a tick with no firing returns a word with fired = 0, no slot or tag, and last set
        if (pend_valid) begin
          ld.slot = SLOT_W'(pend_slot);
          ld.tag  = pend_tag;
        end
        if (dec_fire) begin
          ld_en = pend_valid && out_free;
        end else begin
          ld_en       = out_free;
          ld.last     = 1'b1;
          ld.overflow = found;
        end
      end
      S_FCNT: begin
        alu_i.a    = best_cnt;
        alu_i.b    = '1;
        wr.we_cnt  = 1'b1;
        wr.cnt     = cnt_dec;
        wr.clr_vld = (cnt_dec == '0);
      end
      S_FDUE: begin
        alu_i.a   = best_due;
        alu_i.b   = best_int;
        wr.we_due = 1'b1;
        wr.due    = alu_o.sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      nf         <= '0;
      found      <= 1'b0;
      rd_live    <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      if (ld_en) begin
        res_valid <= 1'b1;
        res_q     <= ld;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            r_type     <= req_t'(req_type);
            r_now      <= now_time;
            r_period   <= period;
            r_first    <= first_delay;
            r_count    <= repeat_count;
            r_tag      <= user_tag;
            r_tgt      <= target_slot;
            nf         <= '0;
            pend_valid <= 1'b0;
            scan_cnt   <= '0;
            rd_live    <= 1'b0;
            found      <= 1'b0;
            if (req_type == REQ_ADD || req_type == REQ_TICK) state <= S_SCAN;
            else state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (r_type == REQ_QUERY) state <= S_QRY;
          else if (out_free) state <= S_IDLE;
        end
        S_QRY: begin
          if (out_free) state <= S_IDLE;
        end
        S_SCAN: begin
          // issue one read a cycle, judge the word read in the previous cycle
          if (scan_cnt < (AW+1)'(NUM_TIMERS)) begin
            scan_cnt <= scan_cnt + (AW+1)'(1);
            rd_idx   <= scan_cnt[AW-1:0];
            rd_live  <= 1'b1;
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live) begin
            if (r_type == REQ_ADD) begin
              if (!rd.vld && !found) begin
                found    <= 1'b1;
                best_idx <= rd_idx;
              end
            end else if (rd.vld && !rd_cnt_zero && alu_o.le && (!found || alu_o.lt)) begin
              // strict compare in ascending order: ties stay on the lower slot
              found    <= 1'b1;
              best_idx <= rd_idx;
              best_due <= rd.due;
              best_int <= rd.intv;
              best_cnt <= rd.cnt;
              best_tag <= rd.tag;
            end
          end
          if (scan_end) state <= (r_type == REQ_ADD) ? S_ADD : S_DECIDE;
        end
        S_ADD: begin
          if (out_free) state <= S_IDLE;
        end
        S_DECIDE: begin
          if (dec_fire) begin
            if (!pend_valid || out_free) state <= S_FCNT;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_FCNT: begin
          pend_valid <= 1'b1;
          pend_slot  <= best_idx;
          pend_tag   <= best_tag;
          nf         <= nf + FW'(1);
          if (cnt_dec == '0) begin
            scan_cnt <= '0;
            rd_live  <= 1'b0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end else begin
            state <= S_FDUE;
          end
        end
        S_FDUE: begin
          scan_cnt <= '0;
          rd_live  <= 1'b0;
          found    <= 1'b0;
          state    <= S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_out   = res_q.slot;
  assign accepted   = res_q.accepted;
  assign fired      = res_q.fired;
  assign tag_out    = res_q.tag;
  assign due_out    = res_q.due;
  assign period_out = res_q.period;
  assign count_out  = res_q.cnt;
  assign overflow   = res_q.overflow;
  assign last       = res_q.last;

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.overflow |-> res_q.last && res_q.fired)
    else $error("overflow on a word that is not the final firing");

  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    nf <= FW'(MAX_FIRES))
    else $error("firing count beyond cap");

  a_idle_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held firing left behind at idle");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after taking a request");

endmodule
